[hw/rtl/sld_pkg.sv]
// Shared types, result codes and constants of the sync/length deframer.
package sld_pkg;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Defaults for the top level parameters and the limit register
   localparam int          LENGTH_BYTES_DEFAULT = 4;
   localparam logic [31:0] MAX_FRAME_RESET      = 32'd65536;

   // Index of the last sync byte
   localparam logic [1:0] SYNC_LAST = 2'd3;

   // Input item as held in the input register
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       restart;
   } item_type;

   // One result item
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [31:0] frame_length;
   } result_type;

   // Sync word 02 03 04 05, by position
   function automatic logic [7:0] sync_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h02;
         2'd1:    val = 8'h03;
         2'd2:    val = 8'h04;
         default: val = 8'h05;
      endcase
      return val;
   endfunction

endpackage

[hw/rtl/sld_in_stage.sv]
// Input register of the deframer with its stall generation.
module sld_in_stage
   import sld_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic       req_restart,
   input  logic       advance,
   output logic       item_valid,
   output item_type   item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;

   // Stall only while a held item cannot move on
   assign req_stall = valid_ff & ~advance;
   assign accept    = req_valid & ~req_stall;

   // Hold, refill or drain the input register
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the payload on each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.rx_byte <= req_rx_byte;
         item_ff.restart <= req_restart;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hw/rtl/sld_core.sv]
// Frame state machine: sync hunt, length capture, payload and tail.
module sld_core
   import sld_pkg::*;
#(
   parameter int LENGTH_BYTES = LENGTH_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        step,
   input  item_type    item,
   output logic        res_valid,
   output result_type  res
);

   localparam int LenCntW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
   localparam logic [LenCntW-1:0] LenLast = LenCntW'(LENGTH_BYTES - 1);

   typedef enum logic [1:0] {
      ST_HUNT,
      ST_LENGTH,
      ST_PAYLOAD,
      ST_TAIL
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        sync_cnt_ff, sync_cnt_in;
   logic [LenCntW-1:0] len_cnt_ff, len_cnt_in;
   logic [31:0]       length_ff, length_in;
   logic [31:0]       left_ff, left_in;
   logic [31:0]       max_len_ff;

   logic [31:0] shifted;
   logic [31:0] shifted_m1;
   logic        bad_len;
   logic        is_sync0;

   assign shifted    = {length_ff[23:0], item.rx_byte};
   assign shifted_m1 = shifted - 32'd1;
   assign bad_len    = (shifted == 32'd0) || (shifted > max_len_ff);
   assign is_sync0   = (item.rx_byte == sync_byte(2'd0));

   // Next state and result for the held item
   always_comb begin
      state_in    = state_ff;
      sync_cnt_in = sync_cnt_ff;
      len_cnt_in  = len_cnt_ff;
      length_in   = length_ff;
      left_in     = left_ff;
      res_valid   = 1'b0;
      res.kind         = KIND_PAYLOAD;
      res.data         = item.rx_byte;
      res.frame_length = length_ff;

      if (item.restart) begin
         // Drop any partial frame
         state_in    = ST_HUNT;
         sync_cnt_in = 2'd0;
         length_in   = 32'd0;
         left_in     = 32'd0;
      end else begin
         case (state_ff)
            ST_HUNT: begin
               if (item.rx_byte == sync_byte(sync_cnt_ff)) begin
                  if (sync_cnt_ff == SYNC_LAST) begin
                     state_in    = ST_LENGTH;
                     sync_cnt_in = 2'd0;
                     len_cnt_in  = '0;
                     length_in   = 32'd0;
                  end else begin
                     sync_cnt_in = sync_cnt_ff + 2'd1;
                  end
               end else begin
                  sync_cnt_in = is_sync0 ? 2'd1 : 2'd0;
               end
            end
            ST_LENGTH: begin
               length_in  = shifted;
               len_cnt_in = len_cnt_ff + 1'b1;
               if (len_cnt_ff == LenLast) begin
                  if (bad_len) begin
                     state_in         = ST_HUNT;
                     length_in        = 32'd0;
                     left_in          = 32'd0;
                     res_valid        = 1'b1;
                     res.kind         = KIND_ERROR;
                     res.data         = 8'd0;
                     res.frame_length = shifted;
                  end else begin
                     left_in  = shifted_m1;
                     state_in = (shifted_m1 == 32'd0) ? ST_TAIL : ST_PAYLOAD;
                  end
               end
            end
            ST_PAYLOAD: begin
               res_valid = 1'b1;
               left_in   = left_ff - 32'd1;
               if (left_ff == 32'd1) begin
                  state_in = ST_TAIL;
               end
            end
            ST_TAIL: begin
               res_valid   = 1'b1;
               res.kind    = KIND_END;
               state_in    = ST_HUNT;
               sync_cnt_in = 2'd0;
               length_in   = 32'd0;
               left_in     = 32'd0;
            end
            default: begin
               state_in    = ST_HUNT;
               sync_cnt_in = is_sync0 ? 2'd1 : 2'd0;
            end
         endcase
      end
   end

   // Frame state and limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_HUNT;
         sync_cnt_ff <= 2'd0;
         len_cnt_ff  <= '0;
         length_ff   <= 32'd0;
         left_ff     <= 32'd0;
         max_len_ff  <= MAX_FRAME_RESET;
      end else begin
         if (step) begin
            state_ff    <= state_in;
            sync_cnt_ff <= sync_cnt_in;
            len_cnt_ff  <= len_cnt_in;
            length_ff   <= length_in;
            left_ff     <= left_in;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

`ifndef SYNTHESIS
   // Payload phase always has bytes still to come
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAYLOAD |-> left_ff != 32'd0)
      else $error("payload phase with no bytes left");

   // Tail phase has no payload left
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAIL |-> left_ff == 32'd0)
      else $error("tail phase with bytes left");

   // Sync match count is clear outside the hunt
   assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_HUNT |-> sync_cnt_ff == 2'd0)
      else $error("stale sync count outside hunt");

   // A length error returns to the hunt
   assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.kind == KIND_ERROR |=> state_ff == ST_HUNT)
      else $error("no return to hunt after length error");
`endif

endmodule

[hw/rtl/sld_out_stage.sv]
// Result register of the deframer.
module sld_out_stage
   import sld_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  res,
   output logic        ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic [31:0] rsp_frame_length
);

   logic       valid_ff, valid_in;
   result_type res_ff;

   // Free when empty or when the held result leaves this cycle
   assign ready = ~valid_ff | ~rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (~rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture a new result
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = res_ff.kind;
   assign rsp_data         = res_ff.data;
   assign rsp_frame_length = res_ff.frame_length;

endmodule

[hw/rtl/sync_length_deframer_unit.sv]
// A byte waits in the input register, passes the frame state machine and its result is
// held in the result register, which drives the outputs; an output stall holds it back.
// Throughput: one byte per cycle while the output does not stall.
// The input register can still take a byte while a finished result waits on the output, if it is empty.
// Reset (synchronous): returns to the sync hunt, clears length and count,
// and sets the frame length limit to 65536.
module sync_length_deframer_unit
   import sld_pkg::*;
#(
   parameter int LENGTH_BYTES = LENGTH_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic [31:0] rsp_frame_length,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   logic       item_valid;
   item_type   item;
   logic       out_ready;
   logic       advance;
   logic       res_valid;
   result_type res;

   // Move the held byte through the state machine when the output can take it
   assign advance = item_valid & out_ready;

   sld_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .req_restart (req_restart),
      .advance     (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   sld_core #(
      .LENGTH_BYTES (LENGTH_BYTES)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (advance),
      .item        (item),
      .res_valid   (res_valid),
      .res         (res)
   );

   sld_out_stage u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (advance & res_valid),
      .res              (res),
      .ready            (out_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_data         (rsp_data),
      .rsp_frame_length (rsp_frame_length)
   );

endmodule
